[hw/rtl/fasta_stream_parser_macros.svh]
// Assertion macros shared by the parser RTL files.
`ifndef FASTA_STREAM_PARSER_MACROS_SVH
`define FASTA_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define FSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fasta parser check failed");
// Check a property on every clock edge, reset included.
`define FSP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fasta parser check failed");
`else
`define FSP_ASSERT(lbl, prop)
`define FSP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[hw/rtl/fsp_pkg.sv]
// Types and constants of the FASTA stream parser.
package fsp_pkg;

  localparam int LenW  = 40;
  localparam int LineW = 32;

  localparam logic [LenW-1:0]  LEN_MAX  = {LenW{1'b1}};
  localparam logic [LineW-1:0] LINE_MAX = {LineW{1'b1}};

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  // Input op codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_DESC = 3'd0;
  localparam logic [2:0] KIND_HEND = 3'd1;
  localparam logic [2:0] KIND_SEQ  = 3'd2;
  localparam logic [2:0] KIND_REND = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_FIRST_BYTE = 2'd0;
  localparam logic [1:0] ERR_EMPTY_SEQ  = 2'd1;
  localparam logic [1:0] ERR_EMPTY_STRM = 2'd2;
  localparam logic [1:0] ERR_OPEN_HDR   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_SEPARATOR = 2'd0;
  localparam logic [1:0] REG_EMIT_DESC = 2'd1;
  localparam logic [1:0] REG_EMIT_SEQ  = 2'd2;
  localparam logic [1:0] REG_EMIT_LEN  = 2'd3;

  localparam logic [7:0] SEPARATOR_RESET = 8'd62;

  typedef enum logic [2:0] {
    ST_EXPECT    = 3'd0,
    ST_HEADER    = 3'd1,
    ST_LINESTART = 3'd2,
    ST_INLINE    = 3'd3,
    ST_HALTED    = 3'd4
  } parse_state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       out_byte;
    logic [LenW-1:0]  record_length;
    logic [LineW-1:0] line_number;
    logic [1:0]       error_code;
  } out_item_t;

endpackage

[hw/rtl/fsp_out_buf.sv]
// Two-entry output buffer: result register plus skid register.
`include "fasta_stream_parser_macros.svh"

module fsp_out_buf
  import fsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      skid_valid;
  out_item_t skid;
  logic      drain;

  // Output register may load when empty or when its beat leaves this cycle
  assign drain = !out_valid || out_ready;
  assign room  = !skid_valid;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload: skid drains first, new beats park in skid when stalled
  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        out_item <= skid;
      end else if (push) begin
        out_item <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

  `FSP_ASSERT(skid_needs_out, skid_valid |-> out_valid)
  `FSP_ASSERT(skid_only_on_stall, $rose(skid_valid) |-> $past(out_valid && !out_ready))
  `FSP_ASSERT(stall_push_parks, (out_valid && !out_ready && push) |=> skid_valid)

endmodule

[hw/rtl/fasta_stream_parser.sv]
// Top level of the FASTA stream parser: byte parser, config registers, output buffer.
// A result beat is registered in the result register, or in the skid register when the output stalls.
// Throughput: one byte per cycle; input stalls only when both the result register
// and the skid register hold beats.
// Bytes that cause no result are still taken one per cycle while the skid register is empty.
// Synchronous reset rearms the parser and loads the register reset values.
`include "fasta_stream_parser_macros.svh"

module fasta_stream_parser
  import fsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] separator_char;
  logic       emit_description;
  logic       emit_sequence;
  logic       emit_length;

  parse_state_t     state, state_next;
  logic [LenW-1:0]  seq_count, seq_count_next;
  logic [LineW-1:0] line_count, line_count_next;

  logic             accept;
  logic             has_res;
  out_item_t        res;
  logic [LenW-1:0]  seq_inc;
  logic [LineW-1:0] line_inc;
  logic             is_sep;
  logic             is_nl;

  assign accept   = in_valid && in_ready;
  assign seq_inc  = (seq_count == LEN_MAX) ? seq_count : seq_count + 1'b1;
  assign line_inc = (line_count == LINE_MAX) ? line_count : line_count + 1'b1;
  assign is_sep   = (in_item.in_byte == separator_char);
  assign is_nl    = (in_item.in_byte == CH_NL);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char   <= SEPARATOR_RESET;
      emit_description <= 1'b1;
      emit_sequence    <= 1'b1;
      emit_length      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEPARATOR: separator_char   <= cfg_data;
        REG_EMIT_DESC: emit_description <= cfg_data[0];
        REG_EMIT_SEQ:  emit_sequence    <= cfg_data[0];
        REG_EMIT_LEN:  emit_length      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next parser state and counters
  always_comb begin
    state_next      = state;
    seq_count_next  = seq_count;
    line_count_next = line_count;
    if (in_item.op == OP_EOS) begin
      state_next      = ST_EXPECT;
      seq_count_next  = '0;
      line_count_next = LineW'(1);
    end else begin
      case (state)
        ST_EXPECT: begin
          state_next = is_sep ? ST_HEADER : ST_HALTED;
        end
        ST_HEADER: begin
          if (is_nl) begin
            seq_count_next  = '0;
            line_count_next = line_inc;
            state_next      = ST_LINESTART;
          end
        end
        ST_LINESTART, ST_INLINE: begin
          if (state == ST_LINESTART && is_sep) begin
            state_next = (seq_count == '0) ? ST_HALTED : ST_HEADER;
          end else if (is_nl) begin
            line_count_next = line_inc;
            state_next      = ST_LINESTART;
          end else begin
            seq_count_next = seq_inc;
            state_next     = ST_INLINE;
          end
        end
        default: state_next = ST_HALTED;
      endcase
    end
  end

  // Result beat for the current byte
  always_comb begin
    has_res           = 1'b0;
    res.kind          = KIND_DESC;
    res.out_byte      = '0;
    res.record_length = '0;
    res.line_number   = line_count;
    res.error_code    = ERR_FIRST_BYTE;
    if (in_item.op == OP_EOS) begin
      case (state)
        ST_EXPECT: begin
          has_res        = 1'b1;
          res.kind       = KIND_ERR;
          res.error_code = ERR_EMPTY_STRM;
        end
        ST_HEADER: begin
          has_res        = 1'b1;
          res.kind       = KIND_ERR;
          res.error_code = ERR_OPEN_HDR;
        end
        ST_LINESTART, ST_INLINE: begin
          if (seq_count == '0) begin
            has_res         = 1'b1;
            res.kind        = KIND_ERR;
            res.error_code  = ERR_EMPTY_SEQ;
            res.line_number = line_count - 1'b1;
          end else if (emit_length) begin
            has_res           = 1'b1;
            res.kind          = KIND_REND;
            res.record_length = seq_count;
          end
        end
        default: ;
      endcase
    end else begin
      case (state)
        ST_EXPECT: begin
          if (!is_sep) begin
            has_res        = 1'b1;
            res.kind       = KIND_ERR;
            res.error_code = ERR_FIRST_BYTE;
          end
        end
        ST_HEADER: begin
          if (is_nl) begin
            has_res  = emit_description;
            res.kind = KIND_HEND;
          end else if (in_item.in_byte != CH_CR) begin
            has_res      = emit_description;
            res.kind     = KIND_DESC;
            res.out_byte = in_item.in_byte;
          end
        end
        ST_LINESTART, ST_INLINE: begin
          if (state == ST_LINESTART && is_sep) begin
            if (seq_count == '0) begin
              has_res         = 1'b1;
              res.kind        = KIND_ERR;
              res.error_code  = ERR_EMPTY_SEQ;
              res.line_number = line_count - 1'b1;
            end else begin
              has_res           = emit_length;
              res.kind          = KIND_REND;
              res.record_length = seq_count;
            end
          end else if (!is_nl && in_item.in_byte != CH_SP && in_item.in_byte != CH_CR) begin
            has_res      = emit_sequence;
            res.kind     = KIND_SEQ;
            res.out_byte = in_item.in_byte;
          end
        end
        default: ;
      endcase
    end
  end

  // Advance parser on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_EXPECT;
      seq_count  <= '0;
      line_count <= LineW'(1);
    end else if (accept) begin
      state      <= state_next;
      seq_count  <= seq_count_next;
      line_count <= line_count_next;
    end
  end

  fsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && has_res),
    .push_data (res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  `FSP_ASSERT(halted_silent, (accept && state == ST_HALTED) |-> !has_res)
  `FSP_ASSERT(eos_rearms,
    (accept && in_item.op == OP_EOS) |=>
      (state == ST_EXPECT && seq_count == '0 && line_count == LineW'(1)))
  `FSP_ASSERT(line_never_zero, line_count != '0)

endmodule
